// ----- sv/fts_pkg.sv -----
// Shared types and constants for the token number scanner.
package fts_pkg;

  localparam int unsigned AccW     = 31;
  localparam int unsigned CntW     = 6;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned CharW    = 8;
  localparam int unsigned MaxToken = 32;

  localparam logic [AccW-1:0] CellMax = {AccW{1'b1}};

  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChNewline   = 8'h0A;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;
  localparam logic [CharW-1:0] ChTab       = 8'h09;
  localparam logic [CharW-1:0] ChCr        = 8'h0D;
  localparam logic [CharW-1:0] ChZero      = 8'h30;
  localparam logic [CharW-1:0] ChNine      = 8'h39;
  localparam logic [CharW-1:0] ChLowA      = 8'h61;
  localparam logic [CharW-1:0] ChLowF      = 8'h66;
  localparam logic [CharW-1:0] ChUpA       = 8'h41;
  localparam logic [CharW-1:0] ChUpF       = 8'h46;
  localparam logic [CharW-1:0] ChLowX      = 8'h78;
  localparam logic [CharW-1:0] ChUpX       = 8'h58;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_END    = 2'd2
  } token_kind_e;

  typedef struct packed {
    token_kind_e       kind;
    logic [CntW-1:0]   length;
    logic [AccW-1:0]   value;
    logic              saturated;
    logic              ended;
  } result_t;

endpackage

// ----- sv/fts_mac_sat.sv -----
// Saturating accumulate-by-base step (base 10 or 16) for one digit.
module fts_mac_sat (
  input  logic [fts_pkg::AccW-1:0]   acc_i,
  input  logic [fts_pkg::DigitW-1:0] digit_i,
  input  logic                       hex_i,
  output logic [fts_pkg::AccW-1:0]   acc_o,
  output logic                       sat_o
);

  localparam int unsigned SumW = fts_pkg::AccW + 5;

  logic [SumW-1:0] prod;
  logic [SumW-1:0] sum;

  always_comb begin
    if (hex_i) begin
      prod = {1'b0, acc_i, 4'b0000};
    end else begin
      // x*10 = x*8 + x*2
      prod = {2'b00, acc_i, 3'b000} + {4'b0000, acc_i, 1'b0};
    end
    sum   = prod + {{(SumW-fts_pkg::DigitW){1'b0}}, digit_i};
    sat_o = sum > {5'b00000, fts_pkg::CellMax};
    acc_o = sat_o ? fts_pkg::CellMax : sum[fts_pkg::AccW-1:0];
  end

endmodule

// ----- sv/fts_scan_core.sv -----
// Tokenizer state, character classification and token report logic.
module fts_scan_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [fts_pkg::CharW-1:0] char_i,
  input  logic                      eoi_i,
  output logic                      res_valid_o,
  output fts_pkg::result_t          res_o
);

  logic                      comment_q, comment_d;
  logic                      inside_q, inside_d;
  logic                      drop_q, drop_d;
  logic [fts_pkg::CntW-1:0]  count_q, count_d;
  logic [fts_pkg::AccW-1:0]  dec_q, dec_d;
  logic [fts_pkg::AccW-1:0]  hex_q, hex_d;
  logic                      dec_flag_q, dec_flag_d;
  logic                      hex_flag_q, hex_flag_d;
  logic                      dec_ovf_q, dec_ovf_d;
  logic                      hex_ovf_q, hex_ovf_d;

  logic                        is_space, is_dig, is_hex;
  logic [fts_pkg::DigitW-1:0]  hex_val;
  logic [fts_pkg::AccW-1:0]    dec_mac, hex_mac;
  logic                        dec_sat, hex_sat;
  logic [fts_pkg::CntW-1:0]    count_inc;
  logic                        dec_ok, hex_ok;
  logic                        comment_next;
  fts_pkg::result_t            tok_res;

  always_comb begin
    is_space = (char_i == fts_pkg::ChSpace) ||
               (char_i >= fts_pkg::ChTab && char_i <= fts_pkg::ChCr);
    is_dig   = char_i >= fts_pkg::ChZero && char_i <= fts_pkg::ChNine;
    is_hex   = 1'b1;
    hex_val  = '0;
    if (is_dig) begin
      hex_val = 4'(char_i - fts_pkg::ChZero);
    end else if (char_i >= fts_pkg::ChLowA && char_i <= fts_pkg::ChLowF) begin
      hex_val = 4'(char_i - fts_pkg::ChLowA + 8'd10);
    end else if (char_i >= fts_pkg::ChUpA && char_i <= fts_pkg::ChUpF) begin
      hex_val = 4'(char_i - fts_pkg::ChUpA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  fts_mac_sat u_dec_mac (
    .acc_i   (dec_q),
    .digit_i (hex_val),
    .hex_i   (1'b0),
    .acc_o   (dec_mac),
    .sat_o   (dec_sat)
  );

  fts_mac_sat u_hex_mac (
    .acc_i   (hex_q),
    .digit_i (hex_val),
    .hex_i   (1'b1),
    .acc_o   (hex_mac),
    .sat_o   (hex_sat)
  );

  // Report of the token held so far; hex form wins over decimal
  always_comb begin
    tok_res.kind      = fts_pkg::KIND_WORD;
    tok_res.length    = count_q;
    tok_res.value     = '0;
    tok_res.saturated = 1'b0;
    tok_res.ended     = 1'b0;
    if (count_q > 6'd2 && hex_flag_q) begin
      tok_res.kind      = fts_pkg::KIND_NUMBER;
      tok_res.value     = hex_q;
      tok_res.saturated = hex_ovf_q;
    end else if (dec_flag_q) begin
      tok_res.kind      = fts_pkg::KIND_NUMBER;
      tok_res.value     = dec_q;
      tok_res.saturated = dec_ovf_q;
    end
  end

  always_comb begin
    count_inc = count_q + 6'd1;
    dec_ok    = (count_q == '0) ? is_dig : (dec_flag_q && is_dig);
    if (count_q == '0) begin
      hex_ok = char_i == fts_pkg::ChZero;
    end else if (count_q == 6'd1) begin
      hex_ok = hex_flag_q && (char_i == fts_pkg::ChLowX || char_i == fts_pkg::ChUpX);
    end else begin
      hex_ok = hex_flag_q && is_hex;
    end
    comment_next = comment_q;
    if (char_i == fts_pkg::ChBackslash) begin
      comment_next = 1'b1;
    end else if (char_i == fts_pkg::ChNewline) begin
      comment_next = 1'b0;
    end
  end

  always_comb begin
    comment_d   = comment_q;
    inside_d    = inside_q;
    drop_d      = drop_q;
    count_d     = count_q;
    dec_d       = dec_q;
    hex_d       = hex_q;
    dec_flag_d  = dec_flag_q;
    hex_flag_d  = hex_flag_q;
    dec_ovf_d   = dec_ovf_q;
    hex_ovf_d   = hex_ovf_q;
    res_valid_o = 1'b0;
    res_o       = tok_res;

    if (go_i) begin
      priority if (eoi_i) begin
        res_valid_o = 1'b1;
        if (inside_q) begin
          res_o.ended = 1'b1;
        end else begin
          res_o.kind      = fts_pkg::KIND_END;
          res_o.length    = '0;
          res_o.value     = '0;
          res_o.saturated = 1'b0;
          res_o.ended     = 1'b1;
        end
        comment_d  = 1'b0;
        inside_d   = 1'b0;
        drop_d     = 1'b0;
        count_d    = '0;
        dec_d      = '0;
        hex_d      = '0;
        dec_flag_d = 1'b0;
        hex_flag_d = 1'b0;
        dec_ovf_d  = 1'b0;
        hex_ovf_d  = 1'b0;
      end else if (inside_q && (drop_q || is_space)) begin
        // full token or whitespace: the character is swallowed and closes the token
        res_valid_o = 1'b1;
        inside_d    = 1'b0;
        drop_d      = 1'b0;
        count_d     = '0;
        dec_d       = '0;
        hex_d       = '0;
        dec_flag_d  = 1'b0;
        hex_flag_d  = 1'b0;
        dec_ovf_d   = 1'b0;
        hex_ovf_d   = 1'b0;
      end else if (inside_q || !(is_space || comment_next)) begin
        if (!inside_q) begin
          comment_d = comment_next;
        end
        inside_d = 1'b1;
        if (is_dig) begin
          dec_d     = dec_mac;
          dec_ovf_d = dec_ovf_q | dec_sat;
        end
        if (count_q >= 6'd2 && is_hex) begin
          hex_d     = hex_mac;
          hex_ovf_d = hex_ovf_q | hex_sat;
        end
        dec_flag_d = dec_ok;
        hex_flag_d = hex_ok;
        count_d    = count_inc;
        drop_d     = count_inc >= 6'(fts_pkg::MaxToken);
      end else begin
        comment_d = comment_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q  <= 1'b0;
      inside_q   <= 1'b0;
      drop_q     <= 1'b0;
      count_q    <= '0;
      dec_q      <= '0;
      hex_q      <= '0;
      dec_flag_q <= 1'b0;
      hex_flag_q <= 1'b0;
      dec_ovf_q  <= 1'b0;
      hex_ovf_q  <= 1'b0;
    end else begin
      comment_q  <= comment_d;
      inside_q   <= inside_d;
      drop_q     <= drop_d;
      count_q    <= count_d;
      dec_q      <= dec_d;
      hex_q      <= hex_d;
      dec_flag_q <= dec_flag_d;
      hex_flag_q <= hex_flag_d;
      dec_ovf_q  <= dec_ovf_d;
      hex_ovf_q  <= hex_ovf_d;
    end
  end

endmodule

// ----- sv/forth_token_number_scanner.sv -----
// Top level: input word register, scanner core and result register.
//
// Input stream: one character per word on s_axis_tdata_i; s_axis_tuser_i set
// marks end of input (character ignored). Output stream: one word per finished
// token, or one end-of-input word when input ends between tokens.
// tuser carries kind (0 number, 1 word, 2 end) and the saturation flag, tdata
// the token length and numeric value, tlast is set when end of input closed it.
// Whitespace between tokens gives no output; a backslash opens a comment that
// runs to newline. Tokens longer than 32 characters are cut, and the following
// character is swallowed.
// A word passes through the input register, then the result register, before
// its result is valid on the master side.
// Throughput: one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// fills; tready on the slave side then drops until the result is taken.
// Reset clears the token and comment state and empties both registers.
module forth_token_number_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tuser_i,   // [0] end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [5:0] token_length, [36:6] number_value, rest zero
  output logic [2:0]  m_axis_tuser_o,   // [1:0] token_kind, [2] value_saturated
  output logic        m_axis_tlast_o    // input_ended
);

  logic                      in_valid_q, in_valid_d;
  logic [fts_pkg::CharW-1:0] in_char_q;
  logic                      in_eoi_q;
  logic                      out_valid_q, out_valid_d;
  fts_pkg::result_t          out_res_q;

  logic                      out_free;
  logic                      go;
  logic                      res_valid;
  fts_pkg::result_t          res;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign go              = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  fts_scan_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .char_i      (in_char_q),
    .eoi_i       (in_eoi_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    if (out_free) begin
      out_valid_d = go && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tuser_i;
    end
    if (go && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_res_q.value, out_res_q.length};
  assign m_axis_tuser_o  = {out_res_q.saturated, out_res_q.kind};
  assign m_axis_tlast_o  = out_res_q.ended;

endmodule
